FILE: sv/nearest_ray_segment_hit_defines.svh
// Assertion helpers for the asserting file of the block.
`ifndef NEAREST_RAY_SEGMENT_HIT_DEFINES_SVH
`define NEAREST_RAY_SEGMENT_HIT_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define NRSH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define NRSH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/nrsh_pkg.sv
package nrsh_pkg;

    localparam int IN_W      = 25;
    localparam int SEG_W     = 12;
    localparam int CFG_W     = 12;
    localparam int OUT_W     = 20;
    localparam int DIST_BITS = 42;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic REG_ORIGIN_X = 1'b0;
    localparam logic REG_ORIGIN_Y = 1'b1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_SUM,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_SUM,
        B_BOX,
        B_CHK,
        B_DIV,
        B_DIST,
        B_SQ,
        B_UPD,
        B_EMIT
    } t_back_state;

    function automatic int job_w(input int cb);
        int a1w;
        a1w = IN_W + 1;
        return 2 + (a1w + cb + 2) + (2 * cb + 3) + (a1w + cb + 2)
            + 2 * a1w + 2 * (cb + 1) + 8 * (cb + 2);
    endfunction

endpackage

FILE: sv/nrsh_in_if.sv
interface nrsh_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [nrsh_pkg::IN_W-1:0]  ray_end_x;
    logic signed [nrsh_pkg::IN_W-1:0]  ray_end_y;
    logic        [nrsh_pkg::SEG_W-1:0] seg_ax;
    logic        [nrsh_pkg::SEG_W-1:0] seg_ay;
    logic        [nrsh_pkg::SEG_W-1:0] seg_bx;
    logic        [nrsh_pkg::SEG_W-1:0] seg_by;
    logic                              last_segment;

    modport source (output valid, ray_end_x, ray_end_y, seg_ax, seg_ay, seg_bx, seg_by,
                    last_segment, input ready);
    modport sink   (input valid, ray_end_x, ray_end_y, seg_ax, seg_ay, seg_bx, seg_by,
                    last_segment, output ready);
endinterface

FILE: sv/nrsh_out_if.sv
interface nrsh_out_if;
    logic                              valid;
    logic                              ready;
    logic [nrsh_pkg::OUT_W-1:0]        hit_x;
    logic [nrsh_pkg::OUT_W-1:0]        hit_y;
    logic                              hit_found;

    modport source (output valid, hit_x, hit_y, hit_found, input ready);
    modport sink   (input valid, hit_x, hit_y, hit_found, output ready);
endinterface

FILE: sv/nrsh_fifo.sv
module nrsh_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [NW-1:0] r_cnt;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

endmodule

FILE: sv/nrsh_front.sv
module nrsh_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    nrsh_in_if.sink                                i_in,
    input  logic [COORD_BITS-1:0]                  i_origin_x,
    input  logic [COORD_BITS-1:0]                  i_origin_y,
    output logic                                   o_push,
    output logic [nrsh_pkg::job_w(COORD_BITS)-1:0] o_job,
    input  logic                                   i_full
);

    localparam int CB  = COORD_BITS;
    localparam int GW  = nrsh_pkg::IN_W;
    localparam int A1W = GW + 1;
    localparam int A2W = CB + 1;
    localparam int C1W = A1W + CB + 2;
    localparam int C2W = 2 * CB + 3;
    localparam int DW  = A1W + A2W + 1;
    localparam int BW  = CB + 2;

    localparam logic signed [GW:0] RAY_LO = (GW + 1)'(-1);
    localparam logic signed [GW:0] RAY_HI = (GW + 1)'(2 ** CB);

    function automatic logic signed [BW-1:0] clamp_ray(input logic signed [GW:0] v);
        logic signed [BW-1:0] r;
        if (v < RAY_LO) begin
            r = BW'(RAY_LO);
        end else if (v > RAY_HI) begin
            r = BW'(RAY_HI);
        end else begin
            r = BW'(v);
        end
        return r;
    endfunction

    nrsh_pkg::t_front_state r_state, n_state;

    logic [CB-1:0]          w_ax, w_ay, w_bx, w_by;
    logic signed [GW:0]     w_gx, w_gy, w_ox, w_oy;
    logic [7:0][BW-1:0]     w_bnd;

    logic signed [A1W-1:0]  r_a1, r_b1;
    logic signed [A2W-1:0]  r_a2, r_b2;
    logic [7:0][BW-1:0]     r_bnd;
    logic                   r_last;
    logic [CB-1:0]          r_ax_hold, r_ay_hold;
    logic signed [A1W+CB:0] r_p_a1ox, r_p_b1oy;
    logic signed [A2W+CB:0] r_p_a2ax, r_p_b2ay;
    logic signed [A1W+A2W-1:0] r_p_a1b2, r_p_a2b1;
    logic signed [C1W-1:0]  r_c1;
    logic signed [C2W-1:0]  r_c2;
    logic signed [DW-1:0]   r_d;
    logic                   r_par;
    logic                   w_take;

    always_comb begin
        w_ax = CB'(i_in.seg_ax);
        w_ay = CB'(i_in.seg_ay);
        w_bx = CB'(i_in.seg_bx);
        w_by = CB'(i_in.seg_by);
        w_gx = (GW + 1)'(i_in.ray_end_x);
        w_gy = (GW + 1)'(i_in.ray_end_y);
        w_ox = $signed((GW + 1)'(i_origin_x));
        w_oy = $signed((GW + 1)'(i_origin_y));
        w_bnd[0] = BW'((w_ax < w_bx) ? w_ax : w_bx);
        w_bnd[1] = BW'((w_ax < w_bx) ? w_bx : w_ax);
        w_bnd[2] = BW'((w_ay < w_by) ? w_ay : w_by);
        w_bnd[3] = BW'((w_ay < w_by) ? w_by : w_ay);
        w_bnd[4] = clamp_ray((w_ox < w_gx) ? w_ox : w_gx);
        w_bnd[5] = clamp_ray((w_ox < w_gx) ? w_gx : w_ox);
        w_bnd[6] = clamp_ray((w_oy < w_gy) ? w_oy : w_gy);
        w_bnd[7] = clamp_ray((w_oy < w_gy) ? w_gy : w_oy);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nrsh_pkg::F_IDLE: begin
                if (i_in.valid) begin
                    n_state = nrsh_pkg::F_MUL;
                end
            end
            nrsh_pkg::F_MUL:  n_state = nrsh_pkg::F_SUM;
            nrsh_pkg::F_SUM:  n_state = nrsh_pkg::F_PUSH;
            nrsh_pkg::F_PUSH: begin
                if (!i_full) begin
                    n_state = nrsh_pkg::F_IDLE;
                end
            end
            default: n_state = nrsh_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == nrsh_pkg::F_IDLE);
        o_push     = (r_state == nrsh_pkg::F_PUSH) && !i_full;
        w_take     = i_in.valid && i_in.ready;
    end

    assign o_job = {r_last, r_par, r_c1, r_c2, r_d, r_a1, r_b1, r_a2, r_b2, r_bnd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nrsh_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a1      <= w_gy - w_oy;
            r_b1      <= w_ox - w_gx;
            r_a2      <= $signed(A2W'(w_by)) - $signed(A2W'(w_ay));
            r_b2      <= $signed(A2W'(w_ax)) - $signed(A2W'(w_bx));
            r_bnd     <= w_bnd;
            r_last    <= i_in.last_segment;
            r_ax_hold <= w_ax;
            r_ay_hold <= w_ay;
        end
        if (r_state == nrsh_pkg::F_MUL) begin
            r_p_a1ox <= r_a1 * $signed({1'b0, i_origin_x});
            r_p_b1oy <= r_b1 * $signed({1'b0, i_origin_y});
            r_p_a2ax <= r_a2 * $signed({1'b0, r_ax_hold});
            r_p_b2ay <= r_b2 * $signed({1'b0, r_ay_hold});
            r_p_a1b2 <= r_a1 * r_b2;
            r_p_a2b1 <= r_a2 * r_b1;
        end
        if (r_state == nrsh_pkg::F_SUM) begin
            r_c1  <= C1W'(r_p_a1ox) + C1W'(r_p_b1oy);
            r_c2  <= C2W'(r_p_a2ax) + C2W'(r_p_b2ay);
            r_d   <= DW'(r_p_a1b2) - DW'(r_p_a2b1);
            r_par <= (r_p_a1b2 == r_p_a2b1);
        end
    end

endmodule

FILE: sv/nrsh_back.sv
module nrsh_back #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_empty,
    output logic                                   o_pop,
    input  logic [nrsh_pkg::job_w(COORD_BITS)-1:0] i_job,
    input  logic [COORD_BITS-1:0]                  i_origin_x,
    input  logic [COORD_BITS-1:0]                  i_origin_y,
    nrsh_out_if.source                             o_out
);

    localparam int CB  = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int GW  = nrsh_pkg::IN_W;
    localparam int A1W = GW + 1;
    localparam int A2W = CB + 1;
    localparam int C1W = A1W + CB + 2;
    localparam int C2W = 2 * CB + 3;
    localparam int DW  = A1W + A2W + 1;
    localparam int BW  = CB + 2;
    localparam int NXW = 2 * CB + GW + 5;
    localparam int PW  = BW + DW + 1;
    localparam int QB  = CB + F + 1;
    localparam int NW  = NXW + F + 2;
    localparam int SW  = DW + 1 + QB;
    localparam int RW  = (NW > SW) ? NW : SW;
    localparam int HW  = CB + F;
    localparam int DSW = 2 * HW + 1;
    localparam int CW  = $clog2(QB + 1);
    localparam logic [DSW-1:0] DMASK = DSW'((64'(1) << nrsh_pkg::DIST_BITS) - 64'(1));

    nrsh_pkg::t_back_state r_state, n_state;

    logic                   w_last, w_par;
    logic signed [C1W-1:0]  w_c1;
    logic signed [C2W-1:0]  w_c2;
    logic signed [DW-1:0]   w_d;
    logic signed [A1W-1:0]  w_a1, w_b1;
    logic signed [A2W-1:0]  w_a2, w_b2;
    logic [7:0][BW-1:0]     w_bnd;

    logic                   r_last, r_par;
    logic signed [C1W-1:0]  r_c1;
    logic signed [C2W-1:0]  r_c2;
    logic signed [DW-1:0]   r_d;
    logic signed [A1W-1:0]  r_a1, r_b1;
    logic signed [A2W-1:0]  r_a2, r_b2;
    logic [7:0][BW-1:0]     r_bnd;

    logic signed [A2W+C1W-1:0] r_m1, r_m4;
    logic signed [A1W+C2W-1:0] r_m2, r_m3;
    logic signed [NXW-1:0]  w_nx, w_ny, r_nx, r_ny;
    logic signed [DW:0]     r_dabs;
    logic signed [PW-1:0]   r_pb [8];
    logic                   w_ok, r_hit;
    logic [RW-1:0]          r_rx, r_ry, r_dsh;
    logic                   w_gex, w_gey;
    logic [QB-1:0]          r_qx, r_qy;
    logic [CW-1:0]          r_cnt;
    logic [HW-1:0]          w_hx, w_hy, w_org_x, w_org_y;
    logic signed [HW:0]     w_sx, w_sy;
    logic [HW-1:0]          r_hx, r_hy, r_ex, r_ey;
    logic [2*HW-1:0]        r_sqx, r_sqy;
    logic [DSW-1:0]         w_dist;
    logic                   w_better;
    logic                   r_have;
    logic [HW-1:0]          r_best_x, r_best_y;
    logic [DSW-1:0]         r_best_d;
    logic                   r_out_valid, r_out_found;
    logic [nrsh_pkg::OUT_W-1:0] r_out_x, r_out_y;
    logic                   w_load_out;

    assign {w_last, w_par, w_c1, w_c2, w_d, w_a1, w_b1, w_a2, w_b2, w_bnd} = i_job;

    always_comb begin
        w_nx = NXW'(r_m1) - NXW'(r_m2);
        w_ny = NXW'(r_m3) - NXW'(r_m4);
        w_ok = (r_nx >= r_pb[0]) && (r_nx <= r_pb[1])
            && (r_ny >= r_pb[2]) && (r_ny <= r_pb[3])
            && (r_nx >= r_pb[4]) && (r_nx <= r_pb[5])
            && (r_ny >= r_pb[6]) && (r_ny <= r_pb[7]);
        w_gex   = (r_rx >= r_dsh);
        w_gey   = (r_ry >= r_dsh);
        w_hx    = HW'(r_qx);
        w_hy    = HW'(r_qy);
        w_org_x = HW'(i_origin_x) << F;
        w_org_y = HW'(i_origin_y) << F;
        w_sx    = $signed({1'b0, w_hx}) - $signed({1'b0, w_org_x});
        w_sy    = $signed({1'b0, w_hy}) - $signed({1'b0, w_org_y});
        w_dist  = DSW'(r_sqx) + DSW'(r_sqy);
        w_better = r_hit && (!r_have || (w_dist < r_best_d));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nrsh_pkg::B_IDLE: begin
                if (!i_empty) begin
                    n_state = nrsh_pkg::B_MUL;
                end
            end
            nrsh_pkg::B_MUL: n_state = nrsh_pkg::B_SUM;
            nrsh_pkg::B_SUM: n_state = r_par ? nrsh_pkg::B_UPD : nrsh_pkg::B_BOX;
            nrsh_pkg::B_BOX: n_state = nrsh_pkg::B_CHK;
            nrsh_pkg::B_CHK: n_state = w_ok ? nrsh_pkg::B_DIV : nrsh_pkg::B_UPD;
            nrsh_pkg::B_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = nrsh_pkg::B_DIST;
                end
            end
            nrsh_pkg::B_DIST: n_state = nrsh_pkg::B_SQ;
            nrsh_pkg::B_SQ:   n_state = nrsh_pkg::B_UPD;
            nrsh_pkg::B_UPD:  n_state = r_last ? nrsh_pkg::B_EMIT : nrsh_pkg::B_IDLE;
            nrsh_pkg::B_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = nrsh_pkg::B_IDLE;
                end
            end
            default: n_state = nrsh_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = (r_state == nrsh_pkg::B_IDLE) && !i_empty;
        w_load_out = (r_state == nrsh_pkg::B_EMIT) && (!r_out_valid || o_out.ready);
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.hit_x     = r_out_x;
    assign o_out.hit_y     = r_out_y;
    assign o_out.hit_found = r_out_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nrsh_pkg::B_IDLE;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_have      <= 1'b0;
            end else begin
                if (o_out.ready) begin
                    r_out_valid <= 1'b0;
                end
                if ((r_state == nrsh_pkg::B_UPD) && w_better) begin
                    r_have <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            nrsh_pkg::B_IDLE: begin
                r_last <= w_last;
                r_par  <= w_par;
                r_c1   <= w_c1;
                r_c2   <= w_c2;
                r_d    <= w_d;
                r_a1   <= w_a1;
                r_b1   <= w_b1;
                r_a2   <= w_a2;
                r_b2   <= w_b2;
                r_bnd  <= w_bnd;
            end
            nrsh_pkg::B_MUL: begin
                r_m1 <= r_b2 * r_c1;
                r_m2 <= r_b1 * r_c2;
                r_m3 <= r_a1 * r_c2;
                r_m4 <= r_a2 * r_c1;
            end
            nrsh_pkg::B_SUM: begin
                r_hit <= 1'b0;
                if (r_d < 0) begin
                    r_nx   <= -w_nx;
                    r_ny   <= -w_ny;
                    r_dabs <= -((DW + 1)'(r_d));
                end else begin
                    r_nx   <= w_nx;
                    r_ny   <= w_ny;
                    r_dabs <= (DW + 1)'(r_d);
                end
            end
            nrsh_pkg::B_BOX: begin
                for (int k = 0; k < 8; k++) begin
                    r_pb[k] <= $signed(r_bnd[k]) * r_dabs;
                end
            end
            nrsh_pkg::B_CHK: begin
                r_hit <= w_ok;
                r_rx  <= (RW'($unsigned(r_nx)) << (F + 1)) + RW'($unsigned(r_dabs));
                r_ry  <= (RW'($unsigned(r_ny)) << (F + 1)) + RW'($unsigned(r_dabs));
                r_dsh <= RW'($unsigned(r_dabs)) << QB;
                r_qx  <= '0;
                r_qy  <= '0;
                r_cnt <= CW'(QB);
            end
            nrsh_pkg::B_DIV: begin
                r_rx  <= w_gex ? r_rx - r_dsh : r_rx;
                r_ry  <= w_gey ? r_ry - r_dsh : r_ry;
                r_qx  <= {r_qx[QB-2:0], w_gex};
                r_qy  <= {r_qy[QB-2:0], w_gey};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - CW'(1);
            end
            nrsh_pkg::B_DIST: begin
                r_hx <= w_hx;
                r_hy <= w_hy;
                r_ex <= (w_sx < 0) ? HW'(-w_sx) : HW'(w_sx);
                r_ey <= (w_sy < 0) ? HW'(-w_sy) : HW'(w_sy);
            end
            nrsh_pkg::B_SQ: begin
                r_sqx <= r_ex * r_ex;
                r_sqy <= r_ey * r_ey;
            end
            nrsh_pkg::B_UPD: begin
                if (w_better) begin
                    r_best_x <= r_hx;
                    r_best_y <= r_hy;
                    r_best_d <= w_dist & DMASK;
                end
            end
            nrsh_pkg::B_EMIT: begin
                if (w_load_out) begin
                    r_out_found <= r_have;
                    r_out_x     <= r_have ? nrsh_pkg::OUT_W'(r_best_x) : '0;
                    r_out_y     <= r_have ? nrsh_pkg::OUT_W'(r_best_y) : '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: sv/nearest_ray_segment_hit.sv
// Nearest ray/segment hit. Write the ray origin through the APB port while idle, then
// stream one wall segment per transfer with the ray's far end; the transfer flagged
// last_segment produces one result with the nearest crossing in 12.8 fixed point, or
// hit_found low and zero coordinates. The front end takes a new transfer once the last is
// pushed into a two-entry queue. The back end multiplies and sums; a parallel segment goes
// to the update, others get box products and a check, and a kept crossing runs the
// one-bit-per-cycle divider, distance and square steps first; a last segment then emits.
module nearest_ray_segment_hit #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nrsh_pkg::APB_AW-1:0]   paddr,
    input  logic [nrsh_pkg::APB_DW-1:0]   pwdata,
    output logic [nrsh_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    nrsh_in_if.sink                       i_in,
    nrsh_out_if.source                    o_out
);

`include "nearest_ray_segment_hit_defines.svh"

    localparam int JW = nrsh_pkg::job_w(COORD_BITS);

    logic [nrsh_pkg::CFG_W-1:0] r_origin_x, r_origin_y;
    logic [COORD_BITS-1:0]      w_ox, w_oy;
    logic                       w_wr;
    logic                       w_push, w_pop, w_full, w_empty;
    logic [JW-1:0]              w_job_in, w_job_out;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_ox   = COORD_BITS'(r_origin_x);
    assign w_oy   = COORD_BITS'(r_origin_y);

    always_comb begin
        if (paddr[2] == nrsh_pkg::REG_ORIGIN_Y) begin
            prdata = nrsh_pkg::APB_DW'(r_origin_y);
        end else begin
            prdata = nrsh_pkg::APB_DW'(r_origin_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (w_wr) begin
            if (paddr[2] == nrsh_pkg::REG_ORIGIN_X) begin
                r_origin_x <= pwdata[nrsh_pkg::CFG_W-1:0];
            end else begin
                r_origin_y <= pwdata[nrsh_pkg::CFG_W-1:0];
            end
        end
    end

    nrsh_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_origin_x (w_ox),
        .i_origin_y (w_oy),
        .o_push     (w_push),
        .o_job      (w_job_in),
        .i_full     (w_full)
    );

    nrsh_fifo #(
        .W     (JW),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_job_out),
        .o_empty (w_empty)
    );

    nrsh_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .i_job      (w_job_out),
        .i_origin_x (w_ox),
        .i_origin_y (w_oy),
        .o_out      (o_out)
    );

    `NRSH_ASSERT_NOW(a_push_room, w_push, !w_full, "push into full queue")
    `NRSH_ASSERT_NOW(a_pop_data, w_pop, !w_empty, "pop from empty queue")
    `NRSH_ASSERT_NEXT(a_pop_frees, w_pop && !w_push, !w_full, "queue full after pop")
    `NRSH_ASSERT_NOW(a_nohit_zero, o_out.valid && !o_out.hit_found, o_out.hit_x == '0 && o_out.hit_y == '0, "no-hit result carries coordinates")

endmodule
